// ----- rtl/fxa_pkg.sv -----
`timescale 1ns / 1ps
// fxa_pkg: shared constants, types and helper functions of the fixed-point alu
// depends on nothing; imported by every module of the block
package fxa_pkg;

   localparam int FRAC_BITS = 8;
   localparam int DATA_W    = 32;
   localparam int OP_W      = 4;
   // dividend of the rounded divide is 2*(|a| << FRAC_BITS) + |b|
   localparam int NUM_W     = DATA_W + FRAC_BITS + 2;
   // divisor of the rounded divide is 2*|b|
   localparam int DEN_W     = DATA_W + 1;
   // back stages: product, one per quotient bit, output
   localparam int LAST      = NUM_W + 1;

   localparam logic [OP_W-1:0] OP_ADD      = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB      = 4'd1;
   localparam logic [OP_W-1:0] OP_MUL      = 4'd2;
   localparam logic [OP_W-1:0] OP_DIV      = 4'd3;
   localparam logic [OP_W-1:0] OP_MIN      = 4'd4;
   localparam logic [OP_W-1:0] OP_MAX      = 4'd5;
   localparam logic [OP_W-1:0] OP_INC      = 4'd6;
   localparam logic [OP_W-1:0] OP_DEC      = 4'd7;
   localparam logic [OP_W-1:0] OP_TO_INT   = 4'd8;
   localparam logic [OP_W-1:0] OP_FROM_INT = 4'd9;

   localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

   // classified word handed from front to back
   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic                     neg;
      logic signed [DATA_W-1:0] res;
      logic                     ovf;
      logic                     dz;
      logic                     eq;
      logic                     lt;
      logic                     gt;
      logic [DATA_W-1:0]        a_mag;
      logic [DATA_W-1:0]        b_mag;
   } item_type;

   // control and result carried along the back pipeline
   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic                     neg;
      logic signed [DATA_W-1:0] res;
      logic                     ovf;
      logic                     dz;
      logic                     eq;
      logic                     lt;
      logic                     gt;
   } stage_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] res;
      logic                     ovf;
   } sat_type;

   // partial remainder and the shared dividend / quotient shift register
   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [NUM_W-1:0] nq;
   } div_type;

   // saturate a signed wide value to the data range
   function automatic sat_type sat_signed(input logic signed [63:0] v);
      sat_type s;
      s.ovf = 1'b0;
      s.res = v[DATA_W-1:0];
      if (v > 64'(MAX_VAL)) begin
         s.ovf = 1'b1;
         s.res = MAX_VAL;
      end else if (v < 64'(MIN_VAL)) begin
         s.ovf = 1'b1;
         s.res = MIN_VAL;
      end
      return s;
   endfunction

   // apply a sign to a magnitude and saturate
   function automatic sat_type sat_mag(input logic [63:0] q, input logic neg);
      sat_type s;
      if (!neg) begin
         s.ovf = q > {32'd0, MAX_VAL};
         s.res = s.ovf ? MAX_VAL : q[DATA_W-1:0];
      end else begin
         s.ovf = q > {32'd0, MIN_VAL};
         s.res = s.ovf ? MIN_VAL : -q[DATA_W-1:0];
      end
      return s;
   endfunction

   // one restoring divide step: one quotient bit
   function automatic div_type div_step(input div_type d, input logic [DEN_W-1:0] den);
      div_type          r;
      logic [DEN_W:0]   t;
      logic             ge;
      t    = {d.rem, d.nq[NUM_W-1]};
      ge   = t >= {1'b0, den};
      r.rem = ge ? DEN_W'(t - {1'b0, den}) : t[DEN_W-1:0];
      r.nq  = {d.nq[NUM_W-2:0], ge};
      return r;
   endfunction

endpackage

// ----- rtl/fxa_front.sv -----
`timescale 1ns / 1ps
// fxa_front: registers the request word and classifies it
// depends on fxa_pkg; feeds fxa_queue
module fxa_front
   import fxa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OP_W-1:0]          req_operation,
   input  logic signed [DATA_W-1:0] req_operand_a,
   input  logic signed [DATA_W-1:0] req_operand_b,
   output logic                     push_valid,
   input  logic                     push_ready,
   output item_type                 push_item
);

   logic                     valid_ff;
   logic [OP_W-1:0]          op_ff;
   logic signed [DATA_W-1:0] a_ff;
   logic signed [DATA_W-1:0] b_ff;
   logic                     take;
   sat_type                  sat;

   // hold while the queue is full
   assign take      = !valid_ff || push_ready;
   assign req_stall = !take;
   assign push_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= req_valid;
      end
      if (take && req_valid) begin
         op_ff <= req_operation;
         a_ff  <= req_operand_a;
         b_ff  <= req_operand_b;
      end
   end

   // compare flags, magnitudes, the divide-by-zero result and all operations but multiply and divide
   always_comb begin
      push_item       = '0;
      push_item.op    = op_ff;
      push_item.neg   = a_ff[DATA_W-1] != b_ff[DATA_W-1];
      push_item.eq    = a_ff == b_ff;
      push_item.lt    = a_ff < b_ff;
      push_item.gt    = a_ff > b_ff;
      push_item.a_mag = a_ff[DATA_W-1] ? DATA_W'(-a_ff) : a_ff;
      push_item.b_mag = b_ff[DATA_W-1] ? DATA_W'(-b_ff) : b_ff;
      sat             = '0;
      case (op_ff)
         OP_ADD:      sat = sat_signed(64'(a_ff) + 64'(b_ff));
         OP_SUB:      sat = sat_signed(64'(a_ff) - 64'(b_ff));
         OP_MIN:      sat.res = (a_ff < b_ff) ? a_ff : b_ff;
         OP_MAX:      sat.res = (a_ff > b_ff) ? a_ff : b_ff;
         OP_INC:      sat = sat_signed(64'(a_ff) + 64'sd1);
         OP_DEC:      sat = sat_signed(64'(a_ff) - 64'sd1);
         OP_TO_INT:   sat.res = a_ff >>> FRAC_BITS;
         OP_FROM_INT: sat = sat_signed(64'(a_ff) <<< FRAC_BITS);
         OP_DIV: begin
            if (b_ff == '0) begin
               push_item.dz = 1'b1;
               sat.res      = a_ff[DATA_W-1] ? MIN_VAL : MAX_VAL;
            end
         end
         default:     sat = '0;
      endcase
      push_item.res = sat.res;
      push_item.ovf = sat.ovf;
   end

endmodule

// ----- rtl/fxa_queue.sv -----
`timescale 1ns / 1ps
// fxa_queue: two-entry queue between front and back
// depends on fxa_pkg
module fxa_queue
   import fxa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type   entry_ff [0:1];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) entry_ff[wr_ptr_ff] <= push_item;
   end

endmodule

// ----- rtl/fxa_back.sv -----
`timescale 1ns / 1ps
// fxa_back: multiply and one-bit-per-stage rounded divide pipeline, result register
// depends on fxa_pkg; fed by fxa_queue
module fxa_back
   import fxa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  item_type                 in_item,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_result,
   output logic                     rsp_is_equal,
   output logic                     rsp_is_less,
   output logic                     rsp_is_greater,
   output logic                     rsp_overflow,
   output logic                     rsp_div_by_zero
);

   logic             valid_ff [0:LAST];
   stage_type        stage_ff [0:LAST];
   stage_type        stage_in [0:LAST];
   div_type          div_ff   [0:LAST];
   div_type          div_in   [0:LAST];
   logic [DEN_W-1:0] den_ff   [0:LAST];
   logic [63:0]      prod_ff;
   logic [63:0]      rounded;
   sat_type          sat_mul;
   sat_type          sat_div;
   logic             advance;

   // whole pipeline moves unless the result word is held
   assign advance  = !(valid_ff[LAST] && rsp_stall);
   assign in_ready = advance;

   // entry stage: product, dividend and divisor
   // mul rounding at stage one, a divide step per stage, divide finish at the end
   always_comb begin
      stage_in[0].op  = in_item.op;
      stage_in[0].neg = in_item.neg;
      stage_in[0].res = in_item.res;
      stage_in[0].ovf = in_item.ovf;
      stage_in[0].dz  = in_item.dz;
      stage_in[0].eq  = in_item.eq;
      stage_in[0].lt  = in_item.lt;
      stage_in[0].gt  = in_item.gt;
      div_in[0].rem   = '0;
      div_in[0].nq    = (NUM_W'(in_item.a_mag) << (FRAC_BITS + 1))
                        + NUM_W'(in_item.b_mag);
      rounded = prod_ff + (64'd1 << (FRAC_BITS - 1));
      sat_mul = sat_mag(rounded >> FRAC_BITS, stage_ff[0].neg);
      sat_div = sat_mag(64'(div_ff[LAST-1].nq), stage_ff[LAST-1].neg);
      for (int k = 1; k <= LAST; k++) begin
         stage_in[k] = stage_ff[k-1];
         div_in[k]   = (k <= NUM_W) ? div_step(div_ff[k-1], den_ff[k-1]) : div_ff[k-1];
      end
      if (stage_ff[0].op == OP_MUL) begin
         stage_in[1].res = sat_mul.res;
         stage_in[1].ovf = sat_mul.ovf;
      end
      if (stage_ff[LAST-1].op == OP_DIV && !stage_ff[LAST-1].dz) begin
         stage_in[LAST].res = sat_div.res;
         stage_in[LAST].ovf = sat_div.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAST; k++) valid_ff[k] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k <= LAST; k++) valid_ff[k] <= valid_ff[k-1];
      end
      if (advance) begin
         prod_ff   <= 64'(in_item.a_mag) * 64'(in_item.b_mag);
         den_ff[0] <= {in_item.b_mag, 1'b0};
         for (int k = 0; k <= LAST; k++) begin
            stage_ff[k] <= stage_in[k];
            div_ff[k]   <= div_in[k];
         end
         for (int k = 1; k <= LAST; k++) den_ff[k] <= den_ff[k-1];
      end
   end

   assign rsp_valid       = valid_ff[LAST];
   assign rsp_result      = stage_ff[LAST].res;
   assign rsp_is_equal    = stage_ff[LAST].eq;
   assign rsp_is_less     = stage_ff[LAST].lt;
   assign rsp_is_greater  = stage_ff[LAST].gt;
   assign rsp_overflow    = stage_ff[LAST].ovf;
   assign rsp_div_by_zero = stage_ff[LAST].dz;

endmodule

// ----- rtl/fixed_point_alu_top.sv -----
`timescale 1ns / 1ps
// fixed_point_alu_top: signed fixed-point alu, front classifier, queue, back pipeline
// depends on fxa_pkg, fxa_front, fxa_queue, fxa_back
//
//   port group   direction   handshake              payload
//   req_         in          req_valid / req_stall  operation, operand_a, operand_b
//   rsp_         out         rsp_valid / rsp_stall  result, compare flags, overflow,
//                                                   div_by_zero
//
// one word per cycle sustained while rsp_stall is low; every operation takes the same
// latency so words leave in order: front register, queue, and NUM_W + 2 back stages
// set by the one-quotient-bit-per-stage divider (44 stages at 8 fraction bits)
// synchronous active-high reset empties all stages and the queue
// a held result stalls the back pipeline, then the queue fills, then req_stall rises
module fixed_point_alu_top
   import fxa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OP_W-1:0]          req_operation,
   input  logic signed [DATA_W-1:0] req_operand_a,
   input  logic signed [DATA_W-1:0] req_operand_b,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_result,
   output logic                     rsp_is_equal,
   output logic                     rsp_is_less,
   output logic                     rsp_is_greater,
   output logic                     rsp_overflow,
   output logic                     rsp_div_by_zero
);

   logic     push_valid;
   logic     push_ready;
   item_type push_item;
   logic     pop_valid;
   logic     pop_ready;
   item_type pop_item;

   fxa_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_item     (push_item)
   );

   fxa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   fxa_back u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (pop_valid),
      .in_ready        (pop_ready),
      .in_item         (pop_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result      (rsp_result),
      .rsp_is_equal    (rsp_is_equal),
      .rsp_is_less     (rsp_is_less),
      .rsp_is_greater  (rsp_is_greater),
      .rsp_overflow    (rsp_overflow),
      .rsp_div_by_zero (rsp_div_by_zero)
   );

endmodule
